// ----- src/vadc_pkg.sv -----
// Package with shared types and constants for the valve actuator duty command block.
package vadc_pkg;

    localparam int unsigned CMD_W    = 16;
    localparam int unsigned VOLT_W   = 16;
    localparam int unsigned DUTY_W   = 10;
    localparam int unsigned PWM_W    = 16;
    localparam int unsigned SCALE_W  = 6;
    localparam int unsigned DVD_W    = 27;
    localparam int unsigned DVS_W    = 24;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned DIV_STAGES = 5;

    localparam logic [DUTY_W-1:0] CMD_LIMIT   = 10'd1023;
    localparam logic [DUTY_W:0]   INVERT_BASE = 11'd1024;

    localparam logic [IDX_W-1:0] REG_LIN_COMP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_REF_VOLT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_VBATT_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_VBATT_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_DUTY_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_DUTY_MAX  = 3'd5;
    localparam logic [IDX_W-1:0] REG_INVERT    = 3'd6;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd7;

    typedef struct packed {
        logic               lin_comp;
        logic [7:0]         ref_volt;
        logic [7:0]         vbatt_min;
        logic [7:0]         vbatt_max;
        logic [7:0]         duty_min;
        logic [7:0]         duty_max;
        logic               invert;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    typedef struct packed {
        logic              enable;
        logic              ign;
        logic              inh;
        logic              lin_comp;
        logic              vzero;
        logic              vneg;
        logic              ovf;
        logic [DUTY_W-1:0] cmd_lim;
    } t_ctl;

    typedef struct packed {
        logic [DVD_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs;
        logic [DUTY_W-1:0] quo;
    } t_div;

endpackage

// ----- src/vadc_cfg.sv -----
// Configuration register file of the valve actuator duty command block.
module vadc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vadc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [vadc_pkg::CFG_W-1:0]  i_cfg_data,
    output vadc_pkg::t_cfg              o_cfg
);
    import vadc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lin_comp  <= 1'b0;
            r_cfg.ref_volt  <= 8'd0;
            r_cfg.vbatt_min <= 8'd0;
            r_cfg.vbatt_max <= 8'd0;
            r_cfg.duty_min  <= 8'd0;
            r_cfg.duty_max  <= 8'd255;
            r_cfg.invert    <= 1'b0;
            r_cfg.scale     <= SCALE_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIN_COMP:  r_cfg.lin_comp  <= i_cfg_data[0];
                REG_REF_VOLT:  r_cfg.ref_volt  <= i_cfg_data;
                REG_VBATT_MIN: r_cfg.vbatt_min <= i_cfg_data;
                REG_VBATT_MAX: r_cfg.vbatt_max <= i_cfg_data;
                REG_DUTY_MIN:  r_cfg.duty_min  <= i_cfg_data;
                REG_DUTY_MAX:  r_cfg.duty_max  <= i_cfg_data;
                REG_INVERT:    r_cfg.invert    <= i_cfg_data[0];
                REG_SCALE:     r_cfg.scale     <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- src/vadc_front.sv -----
// Front stages: enable window, dividend product and divider setup.
module vadc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  vadc_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    input  logic [vadc_pkg::CMD_W-1:0]   i_cmd,
    input  logic signed [vadc_pkg::VOLT_W-1:0] i_volt,
    input  logic                         i_ign,
    input  logic                         i_inh,
    output logic                         o_valid,
    output vadc_pkg::t_ctl               o_ctl,
    output vadc_pkg::t_div               o_div
);
    import vadc_pkg::*;

    logic                      r_v1;
    t_ctl                      r_ctl1;
    logic [DVD_W-1:0]          r_dvd1;
    logic [VOLT_W-1:0]         r_volt1;
    logic                      r_v2;
    t_ctl                      r_ctl2;
    t_div                      r_div2;

    logic signed [VOLT_W-1:0]  lo_thr;
    logic signed [VOLT_W-1:0]  hi_thr;
    logic [23:0]               prod;
    t_ctl                      n_ctl1;
    t_ctl                      n_ctl2;
    t_div                      n_div2;
    logic                      vpos;

    always_comb begin
        lo_thr = {5'd0, i_cfg.vbatt_min, 3'd0};
        hi_thr = {5'd0, i_cfg.vbatt_max, 3'd0};
        prod   = i_cmd * i_cfg.ref_volt;
        n_ctl1.enable   = (i_volt > lo_thr) && (i_volt < hi_thr);
        n_ctl1.ign      = i_ign;
        n_ctl1.inh      = i_inh;
        n_ctl1.lin_comp = i_cfg.lin_comp;
        n_ctl1.vzero    = (i_volt == '0);
        n_ctl1.vneg     = i_volt[VOLT_W-1];
        n_ctl1.ovf      = 1'b0;
        n_ctl1.cmd_lim  = (i_cmd > CMD_W'(CMD_LIMIT)) ? CMD_LIMIT : i_cmd[DUTY_W-1:0];
    end

    always_comb begin
        vpos       = !r_ctl1.vzero && !r_ctl1.vneg;
        n_ctl2     = r_ctl1;
        n_ctl2.ovf = vpos && (r_dvd1[DVD_W-1:DUTY_W] >= {2'd0, r_volt1[VOLT_W-2:0]});
        n_div2.rem = r_dvd1;
        n_div2.dvs = vpos ? {r_volt1[VOLT_W-2:0], 9'd0} : '0;
        n_div2.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl1  <= n_ctl1;
            r_dvd1  <= {prod, 3'd0};
            r_volt1 <= i_volt;
            r_ctl2  <= n_ctl2;
            r_div2  <= n_div2;
        end
    end

    assign o_valid = r_v2;
    assign o_ctl   = r_ctl2;
    assign o_div   = r_div2;

endmodule

// ----- src/vadc_div_step.sv -----
// One divider stage that resolves two quotient bits by restoring division.
module vadc_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  vadc_pkg::t_ctl i_ctl,
    input  vadc_pkg::t_div i_div,
    output logic           o_valid,
    output vadc_pkg::t_ctl o_ctl,
    output vadc_pkg::t_div o_div
);
    import vadc_pkg::*;

    logic             r_valid;
    t_ctl             r_ctl;
    t_div             r_div;

    logic [DVD_W-1:0] d_hi;
    logic [DVD_W-1:0] d_lo;
    logic [DVD_W-1:0] rem_mid;
    logic             b_hi;
    logic             b_lo;
    t_div             n_div;

    always_comb begin
        d_hi    = {3'd0, i_div.dvs};
        b_hi    = (i_div.rem >= d_hi);
        rem_mid = b_hi ? (i_div.rem - d_hi) : i_div.rem;
        d_lo    = {4'd0, i_div.dvs[DVS_W-1:1]};
        b_lo    = (rem_mid >= d_lo);
        n_div.rem = b_lo ? (rem_mid - d_lo) : rem_mid;
        n_div.dvs = {2'd0, i_div.dvs[DVS_W-1:2]};
        n_div.quo = {i_div.quo[DUTY_W-3:0], b_hi, b_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_div   = r_div;

endmodule

// ----- src/vadc_back.sv -----
// Output stage: command selection, duty clamping, inversion, scaling and gating.
module vadc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  vadc_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  vadc_pkg::t_ctl                i_ctl,
    input  logic [vadc_pkg::DUTY_W-1:0]   i_quo,
    output logic                          o_valid,
    output logic                          o_drive_enable,
    output logic                          o_dormant_request,
    output logic [vadc_pkg::DUTY_W-1:0]   o_compensated_command,
    output logic [vadc_pkg::DUTY_W-1:0]   o_applied_duty,
    output logic [vadc_pkg::PWM_W-1:0]    o_pwm_command
);
    import vadc_pkg::*;

    logic              r_valid;
    logic              r_enable;
    logic              r_dormant;
    logic [DUTY_W-1:0] r_comp;
    logic [DUTY_W-1:0] r_applied;
    logic [PWM_W-1:0]  r_pwm;

    logic [DUTY_W-1:0] comp;
    logic [DUTY_W-1:0] lo;
    logic [DUTY_W-1:0] hi;
    logic [DUTY_W-1:0] d_floor;
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W:0]   inv;
    logic [DUTY_W-1:0] applied;
    logic [PWM_W-1:0]  pwm;
    logic              dormant;

    always_comb begin
        if (!i_ctl.lin_comp) begin
            comp = i_ctl.cmd_lim;
        end else if (i_ctl.vzero || i_ctl.ovf) begin
            comp = CMD_LIMIT;
        end else if (i_ctl.vneg) begin
            comp = '0;
        end else begin
            comp = i_quo;
        end
        dormant = (comp == '0);
        lo      = {i_cfg.duty_min, 2'd0};
        hi      = {i_cfg.duty_max, 2'd0};
        d_floor = (comp < lo) ? lo : comp;
        if (!dormant && i_ctl.enable) begin
            duty = (d_floor > hi) ? hi : d_floor;
        end else begin
            duty = '0;
        end
        inv = INVERT_BASE - {1'b0, duty};
        if (i_cfg.invert) begin
            applied = inv[DUTY_W] ? CMD_LIMIT : inv[DUTY_W-1:0];
        end else begin
            applied = duty;
        end
        pwm = applied * i_cfg.scale;
        if (!i_ctl.ign || i_ctl.inh) begin
            pwm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_enable  <= i_ctl.enable;
            r_dormant <= dormant;
            r_comp    <= comp;
            r_applied <= applied;
            r_pwm     <= pwm;
        end
    end

    assign o_valid               = r_valid;
    assign o_drive_enable        = r_enable;
    assign o_dormant_request     = r_dormant;
    assign o_compensated_command = r_comp;
    assign o_applied_duty        = r_applied;
    assign o_pwm_command         = r_pwm;

endmodule

// ----- src/valve_actuator_duty_command.sv -----
// Valve actuator duty command block: eight-stage pipeline from input transfer to result.
// Throughput is one item per cycle while the output is not stalled; the
// two-bit-per-stage divider chain sets the depth.
// A stall on the output holds every stage, so input is stalled only while a result waits.
// Synchronous active-low reset clears the valid bits and loads the register reset values.
module valve_actuator_duty_command (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [15:0]                   i_requested_command,
    input  logic signed [15:0]            i_battery_voltage,
    input  logic                          i_ignition_on,
    input  logic                          i_command_inhibit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_drive_enable,
    output logic                          o_dormant_request,
    output logic [9:0]                    o_compensated_command,
    output logic [9:0]                    o_applied_duty,
    output logic [15:0]                   o_pwm_command,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vadc_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [vadc_pkg::CFG_W-1:0]    i_cfg_data
);
    import vadc_pkg::*;

    t_cfg cfg;
    logic en;
    logic v_pipe   [DIV_STAGES+1];
    t_ctl ctl_pipe [DIV_STAGES+1];
    t_div div_pipe [DIV_STAGES+1];

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    vadc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vadc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .i_cmd   (i_requested_command),
        .i_volt  (i_battery_voltage),
        .i_ign   (i_ignition_on),
        .i_inh   (i_command_inhibit),
        .o_valid (v_pipe[0]),
        .o_ctl   (ctl_pipe[0]),
        .o_div   (div_pipe[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        vadc_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_pipe[g]),
            .i_ctl   (ctl_pipe[g]),
            .i_div   (div_pipe[g]),
            .o_valid (v_pipe[g+1]),
            .o_ctl   (ctl_pipe[g+1]),
            .o_div   (div_pipe[g+1])
        );
    end

    vadc_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_en                  (en),
        .i_cfg                 (cfg),
        .i_valid               (v_pipe[DIV_STAGES]),
        .i_ctl                 (ctl_pipe[DIV_STAGES]),
        .i_quo                 (div_pipe[DIV_STAGES].quo),
        .o_valid               (o_out_valid),
        .o_drive_enable        (o_drive_enable),
        .o_dormant_request     (o_dormant_request),
        .o_compensated_command (o_compensated_command),
        .o_applied_duty        (o_applied_duty),
        .o_pwm_command         (o_pwm_command)
    );

`ifndef ASSERT_OFF
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("Input stalled without a held result.");

    a_idle_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drive_enable && !cfg.invert) |-> (o_applied_duty == '0))
        else $error("Duty not zero while drive is disabled.");

    a_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_enable && !o_dormant_request && !cfg.invert)
        |-> (o_applied_duty <= {cfg.duty_max, 2'd0}))
        else $error("Applied duty above the ceiling.");

    a_dormant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dormant_request && cfg.invert) |-> (o_applied_duty == CMD_LIMIT))
        else $error("Dormant command not inverted to full duty.");
`endif

endmodule
